// ===== src/quaternion_slerp_unit_macros.svh =====
// assertion macros for the quaternion interpolation unit
`ifndef QUATERNION_SLERP_UNIT_MACROS_SVH
`define QUATERNION_SLERP_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define QS_CHECK(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("qslerp check failed");

// next-cycle implication, masked during reset
`define QS_CHECK_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("qslerp check failed");

// next-cycle implication, also live during reset
`define QS_CHECK_RST(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("qslerp reset check failed");

`endif

// ===== src/qslerp_pkg.sv =====
// shared constants and types for the quaternion interpolation unit
`default_nettype none
package qslerp_pkg;
  localparam int CORDIC_STEPS = 30;
  localparam int ROOT_STEPS   = 31;
  localparam int DIV_STEPS    = 31;
  localparam int ANG_W        = 34;
  localparam int T_W          = 16;
  localparam int THR_W        = 15;
  localparam int CFG_IDX_W    = 1;

  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [31:0] INV_GAIN = 32'd652032874;
  localparam logic [15:0] T_ONE    = 16'h8000;
  localparam logic        MODE_SPH = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 1'b0,
    CFG_THRESH = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic sph;
    logic sat;
  } qs_flags_t;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
  };
endpackage
`default_nettype wire

// ===== src/qslerp_if.sv =====
// handshake interfaces for the input, result and configuration channels
`default_nettype none
interface qslerp_in_if #(parameter int B = 16) ();
  logic                valid;
  logic                ready;
  logic signed [B-1:0] first_x;
  logic signed [B-1:0] first_y;
  logic signed [B-1:0] first_z;
  logic signed [B-1:0] first_w;
  logic signed [B-1:0] second_x;
  logic signed [B-1:0] second_y;
  logic signed [B-1:0] second_z;
  logic signed [B-1:0] second_w;
  logic [15:0]         interp_t;
  modport source (output valid, first_x, first_y, first_z, first_w,
                  second_x, second_y, second_z, second_w, interp_t, input ready);
  modport sink (input valid, first_x, first_y, first_z, first_w,
                second_x, second_y, second_z, second_w, interp_t, output ready);
endinterface

interface qslerp_out_if #(parameter int B = 16) ();
  logic                valid;
  logic                ready;
  logic signed [B-1:0] out_x;
  logic signed [B-1:0] out_y;
  logic signed [B-1:0] out_z;
  logic signed [B-1:0] out_w;
  logic                saturated;
  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

interface qslerp_cfg_if import qslerp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [THR_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/qslerp_dot.sv =====
// dot product, shortest-path sign fix, clamp and sine-squared operand
`default_nettype none
module qslerp_dot import qslerp_pkg::*; #(
  parameter int B = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 valid_i,
  input  logic [4*B-1:0]       a_i,
  input  logic [4*B-1:0]       b_i,
  input  logic [T_W-1:0]       t_i,
  input  logic                 mode_i,
  input  logic [THR_W-1:0]     thr_i,
  output logic                 valid_o,
  output logic [8*B+4+T_W-1:0] base_o,
  output logic [30:0]          c_o,
  output logic [60:0]          v_o,
  output qs_flags_t            flags_o
);
  localparam int F  = B - 2;
  localparam int DW = B + 4;
  localparam int BW = 8 * B + 4 + T_W;
  localparam logic [DW-1:0] ONE = DW'(1) << F;

  logic                  vld1_r, vld2_r, vld3_r, vld4_r, vld5_r;
  logic signed [2*B-1:0] prod1_r [4];
  logic [4*B-1:0]        a1_r, a2_r, b1_r, b2_r;
  logic [T_W-1:0]        t1_r, t2_r;
  logic signed [DW-1:0]  dsum, d2_r;
  logic [BW-1:0]         base3_r, base4_r, base5_r;
  logic [30:0]           c3_r, c4_r, c5_r;
  logic [61:0]           cc4_r;
  logic [60:0]           v5_r;
  qs_flags_t             flg3_r, flg4_r, flg5_r;

  logic                  neg, sph_mode, big;
  logic [DW-1:0]         dabs, dc, diff;
  logic [4*(B+1)-1:0]    bn;
  logic [T_W-1:0]        tc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= valid_i;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
    end
  end

  always_comb begin
    dsum = '0;
    for (int i = 0; i < 4; i++) begin
      dsum = dsum + DW'(prod1_r[i] >>> F);
    end
  end

  always_comb begin
    neg      = d2_r[DW-1];
    dabs     = neg ? DW'(-d2_r) : DW'(d2_r);
    for (int i = 0; i < 4; i++) begin
      bn[i*(B+1) +: B+1] = neg ? -{b2_r[i*B+B-1], b2_r[i*B +: B]}
                               : {b2_r[i*B+B-1], b2_r[i*B +: B]};
    end
    tc       = (t2_r > T_ONE) ? T_ONE : t2_r;
    sph_mode = (mode_i == MODE_SPH);
    big      = dabs > ONE;
    dc       = (sph_mode && big) ? ONE : dabs;
    diff     = ONE - dc;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        prod1_r[i] <= $signed(a_i[i*B +: B]) * $signed(b_i[i*B +: B]);
      end
      a1_r    <= a_i;
      b1_r    <= b_i;
      t1_r    <= t_i;
      d2_r    <= dsum;
      a2_r    <= a1_r;
      b2_r    <= b1_r;
      t2_r    <= t1_r;
      base3_r <= {tc, bn, a2_r};
      c3_r    <= 31'(dc) << (30 - F);
      flg3_r.sat <= sph_mode && big;
      flg3_r.sph <= sph_mode && (diff > DW'(thr_i));
      cc4_r   <= 62'(c3_r) * 62'(c3_r);
      base4_r <= base3_r;
      c4_r    <= c3_r;
      flg4_r  <= flg3_r;
      v5_r    <= 61'((62'(1) << 60) - cc4_r);
      base5_r <= base4_r;
      c5_r    <= c4_r;
      flg5_r  <= flg4_r;
    end
  end

  assign valid_o = vld5_r;
  assign base_o  = base5_r;
  assign c_o     = c5_r;
  assign v_o     = v5_r;
  assign flags_o = flg5_r;
endmodule
`default_nettype wire

// ===== src/qslerp_isqrt.sv =====
// pipelined integer square root, one result bit per stage
`default_nettype none
module qslerp_isqrt import qslerp_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              valid_i,
  input  logic [60:0]       v_i,
  input  qs_flags_t         flags_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [30:0]       s_o,
  output qs_flags_t         flags_o,
  output logic [SIDE_W-1:0] side_o
);
  localparam int N = ROOT_STEPS;

  logic [61:0]       rem_r  [N-1];
  logic [61:0]       root_r [N];
  logic              vld_r  [N];
  qs_flags_t         flg_r  [N];
  logic [SIDE_W-1:0] side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [61:0] BITK = 62'(1) << (60 - 2 * k);
    logic [61:0]       rem_p, root_p, trial;
    logic              vld_p, take;
    qs_flags_t         flg_p;
    logic [SIDE_W-1:0] side_p;

    if (k == 0) begin : g_first
      assign rem_p  = {1'b0, v_i};
      assign root_p = '0;
      assign vld_p  = valid_i;
      assign flg_p  = flags_i;
      assign side_p = side_i;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign vld_p  = vld_r[k-1];
      assign flg_p  = flg_r[k-1];
      assign side_p = side_r[k-1];
    end

    assign trial = root_p + BITK;
    assign take  = rem_p >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        root_r[k] <= take ? (root_p >> 1) + BITK : root_p >> 1;
        flg_r[k]  <= flg_p;
        side_r[k] <= side_p;
      end
    end

    if (k < N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k] <= take ? rem_p - trial : rem_p;
        end
      end
    end
  end

  assign valid_o     = vld_r[N-1];
  assign s_o         = root_r[N-1][30:0];
  assign flags_o.sph = flg_r[N-1].sph && (root_r[N-1][30:0] != '0);
  assign flags_o.sat = flg_r[N-1].sat;
  assign side_o      = side_r[N-1];
endmodule
`default_nettype wire

// ===== src/qslerp_atan.sv =====
// pipelined vectoring cordic giving the angle of (cosine, sine)
`default_nettype none
module qslerp_atan import qslerp_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              valid_i,
  input  logic [30:0]       c_i,
  input  logic [30:0]       s_i,
  input  qs_flags_t         flags_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [30:0]       theta_o,
  output qs_flags_t         flags_o,
  output logic [SIDE_W-1:0] side_o
);
  localparam int N = CORDIC_STEPS;
  localparam int W = ANG_W;

  logic signed [W-1:0] x_r [N-1];
  logic signed [W-1:0] y_r [N-1];
  logic signed [W-1:0] z_r [N];
  logic                vld_r [N];
  qs_flags_t           flg_r [N];
  logic [SIDE_W-1:0]   side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic signed [W-1:0] AT = $signed({2'b00, ATAN_TAB[k]});
    logic signed [W-1:0] x_p, y_p, z_p, dx, dy;
    logic                vld_p;
    qs_flags_t           flg_p;
    logic [SIDE_W-1:0]   side_p;

    if (k == 0) begin : g_first
      assign x_p    = $signed({3'b000, c_i});
      assign y_p    = $signed({3'b000, s_i});
      assign z_p    = '0;
      assign vld_p  = valid_i;
      assign flg_p  = flags_i;
      assign side_p = side_i;
    end else begin : g_next
      assign x_p    = x_r[k-1];
      assign y_p    = y_r[k-1];
      assign z_p    = z_r[k-1];
      assign vld_p  = vld_r[k-1];
      assign flg_p  = flg_r[k-1];
      assign side_p = side_r[k-1];
    end

    assign dx = y_p >>> k;
    assign dy = x_p >>> k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        z_r[k]    <= y_p[W-1] ? z_p - AT : z_p + AT;
        flg_r[k]  <= flg_p;
        side_r[k] <= side_p;
      end
    end

    if (k < N - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (adv) begin
          x_r[k] <= y_p[W-1] ? x_p - dx : x_p + dx;
          y_r[k] <= y_p[W-1] ? y_p + dy : y_p - dy;
        end
      end
    end
  end

  assign valid_o = vld_r[N-1];
  assign theta_o = z_r[N-1][W-1] ? '0 : z_r[N-1][30:0];
  assign flags_o = flg_r[N-1];
  assign side_o  = side_r[N-1];
endmodule
`default_nettype wire

// ===== src/qslerp_sin2.sv =====
// angle split by the fraction and two pipelined rotation cordic sines
`default_nettype none
module qslerp_sin2 import qslerp_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              valid_i,
  input  logic [30:0]       theta_i,
  input  logic [T_W-1:0]    t_i,
  input  qs_flags_t         flags_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [30:0]       sine0_o,
  output logic [30:0]       sine1_o,
  output qs_flags_t         flags_o,
  output logic [SIDE_W-1:0] side_o
);
  localparam int N = CORDIC_STEPS;
  localparam int W = ANG_W;

  logic [46:0]         p0, p1;
  logic [30:0]         ang_r [2];
  logic                vld0_r;
  qs_flags_t           flg0_r;
  logic [SIDE_W-1:0]   side0_r;

  logic signed [W-1:0] x_r [2][N-1];
  logic signed [W-1:0] y_r [2][N];
  logic signed [W-1:0] z_r [2][N-1];
  logic                vld_r [N];
  qs_flags_t           flg_r [N];
  logic [SIDE_W-1:0]   side_r [N];
  logic [30:0]         sine [2];

  assign p0 = 47'(theta_i) * 47'(T_ONE - t_i);
  assign p1 = 47'(theta_i) * 47'(t_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r[0] <= p0[45:15];
      ang_r[1] <= p1[45:15];
      flg0_r   <= flags_i;
      side0_r  <= side_i;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic              vld_p;
    qs_flags_t         flg_p;
    logic [SIDE_W-1:0] side_p;

    if (k == 0) begin : g_first
      assign vld_p  = vld0_r;
      assign flg_p  = flg0_r;
      assign side_p = side0_r;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign flg_p  = flg_r[k-1];
      assign side_p = side_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        flg_r[k]  <= flg_p;
        side_r[k] <= side_p;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      localparam logic signed [W-1:0] AT = $signed({2'b00, ATAN_TAB[k]});
      logic signed [W-1:0] x_p, y_p, z_p, dx, dy;

      if (k == 0) begin : g_first
        assign x_p = $signed({2'b00, INV_GAIN});
        assign y_p = '0;
        assign z_p = $signed({3'b000, ang_r[l]});
      end else begin : g_next
        assign x_p = x_r[l][k-1];
        assign y_p = y_r[l][k-1];
        assign z_p = z_r[l][k-1];
      end

      assign dx = y_p >>> k;
      assign dy = x_p >>> k;

      always_ff @(posedge clk) begin
        if (adv) begin
          y_r[l][k] <= z_p[W-1] ? y_p - dy : y_p + dy;
        end
      end

      if (k < N - 1) begin : g_xz
        always_ff @(posedge clk) begin
          if (adv) begin
            x_r[l][k] <= z_p[W-1] ? x_p + dx : x_p - dx;
            z_r[l][k] <= z_p[W-1] ? z_p + AT : z_p - AT;
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (y_r[l][N-1][W-1]) begin
        sine[l] = '0;
      end else if (y_r[l][N-1] > $signed({3'b000, ONE_Q30})) begin
        sine[l] = ONE_Q30;
      end else begin
        sine[l] = y_r[l][N-1][30:0];
      end
    end
  end

  assign valid_o = vld_r[N-1];
  assign sine0_o = sine[0];
  assign sine1_o = sine[1];
  assign flags_o = flg_r[N-1];
  assign side_o  = side_r[N-1];
endmodule
`default_nettype wire

// ===== src/qslerp_div2.sv =====
// two pipelined restoring dividers forming the interpolation weights
`default_nettype none
module qslerp_div2 import qslerp_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              valid_i,
  input  logic [30:0]       sine0_i,
  input  logic [30:0]       sine1_i,
  input  logic [30:0]       s_i,
  input  qs_flags_t         flags_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [30:0]       k0_o,
  output logic [30:0]       k1_o,
  output qs_flags_t         flags_o,
  output logic [SIDE_W-1:0] side_o
);
  localparam int N = DIV_STEPS;

  logic [30:0]       sine_in [2];
  logic [30:0]       rem_r [2][N-1];
  logic [30:0]       q_r   [2][N];
  logic              ovf_r [2][N];
  logic [30:0]       s_r   [N-1];
  logic              vld_r [N];
  qs_flags_t         flg_r [N];
  logic [SIDE_W-1:0] side_r [N];
  logic [30:0]       wgt [2];

  assign sine_in[0] = sine0_i;
  assign sine_in[1] = sine1_i;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [30:0]       s_p;
    logic              vld_p;
    qs_flags_t         flg_p;
    logic [SIDE_W-1:0] side_p;

    if (k == 0) begin : g_first
      assign s_p    = s_i;
      assign vld_p  = valid_i;
      assign flg_p  = flags_i;
      assign side_p = side_i;
    end else begin : g_next
      assign s_p    = s_r[k-1];
      assign vld_p  = vld_r[k-1];
      assign flg_p  = flg_r[k-1];
      assign side_p = side_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        flg_r[k]  <= flg_p;
        side_r[k] <= side_p;
      end
    end

    if (k < N - 1) begin : g_s
      always_ff @(posedge clk) begin
        if (adv) begin
          s_r[k] <= s_p;
        end
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [30:0] rem_p, q_p;
      logic        ovf_p, in_bit, ge;
      logic [31:0] trial, diff;

      if (k == 0) begin : g_first
        assign rem_p  = {1'b0, sine_in[l][30:1]};
        assign q_p    = '0;
        assign ovf_p  = {1'b0, sine_in[l]} >= {s_i, 1'b0};
        assign in_bit = sine_in[l][0];
      end else begin : g_next
        assign rem_p  = rem_r[l][k-1];
        assign q_p    = q_r[l][k-1];
        assign ovf_p  = ovf_r[l][k-1];
        assign in_bit = 1'b0;
      end

      assign trial = {rem_p, in_bit};
      assign ge    = trial >= {1'b0, s_p};
      assign diff  = trial - {1'b0, s_p};

      always_ff @(posedge clk) begin
        if (adv) begin
          q_r[l][k]   <= {q_p[29:0], ge};
          ovf_r[l][k] <= ovf_p;
        end
      end

      if (k < N - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (adv) begin
            rem_r[l][k] <= ge ? diff[30:0] : trial[30:0];
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (ovf_r[l][N-1] || (q_r[l][N-1] > ONE_Q30)) begin
        wgt[l] = ONE_Q30;
      end else begin
        wgt[l] = q_r[l][N-1];
      end
    end
  end

  assign valid_o = vld_r[N-1];
  assign k0_o    = wgt[0];
  assign k1_o    = wgt[1];
  assign flags_o = flg_r[N-1];
  assign side_o  = side_r[N-1];
endmodule
`default_nettype wire

// ===== src/qslerp_mix.sv =====
// weight selection, weighted sum, rounding and saturation into the output register
`default_nettype none
module qslerp_mix import qslerp_pkg::*; #(
  parameter int B = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 valid_i,
  input  logic [8*B+4+T_W-1:0] base_i,
  input  logic [30:0]          k0_i,
  input  logic [30:0]          k1_i,
  input  qs_flags_t            flags_i,
  output logic                 valid_o,
  output logic [4*B-1:0]       r_o,
  output logic                 sat_o
);
  localparam int PW = B + 33;
  localparam int SW = B + 35;
  localparam int RW = SW - 30;
  localparam logic signed [SW-1:0] RND = SW'(1) << 29;
  localparam logic signed [RW-1:0] HI  = RW'((1 << (B - 1)) - 1);
  localparam logic signed [RW-1:0] LO  = -HI - RW'(1);

  logic [T_W-1:0]       t;
  logic [30:0]          kk0, kk1;
  logic signed [PW-1:0] p0_r [4];
  logic signed [PW-1:0] p1_r [4];
  logic                 vld1_r, sat1_r, vld2_r, sat2_r;
  logic [4*B-1:0]       r2_r, r_nxt;
  logic                 sat_nxt;
  logic signed [SW-1:0] sum;
  logic signed [RW-1:0] rr;

  assign t   = base_i[8*B+4 +: T_W];
  assign kk0 = flags_i.sph ? k0_i : {T_ONE - t, 15'b0};
  assign kk1 = flags_i.sph ? k1_i : {t, 15'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= valid_i;
      vld2_r <= vld1_r;
    end
  end

  always_comb begin
    sat_nxt = sat1_r;
    r_nxt   = '0;
    sum     = '0;
    rr      = '0;
    for (int i = 0; i < 4; i++) begin
      sum = SW'(p0_r[i]) + SW'(p1_r[i]) + RND;
      rr  = RW'(sum >>> 30);
      if (rr > HI) begin
        r_nxt[i*B +: B] = HI[B-1:0];
        sat_nxt = 1'b1;
      end else if (rr < LO) begin
        r_nxt[i*B +: B] = LO[B-1:0];
        sat_nxt = 1'b1;
      end else begin
        r_nxt[i*B +: B] = rr[B-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        p0_r[i] <= $signed(base_i[i*B +: B]) * $signed({1'b0, kk0});
        p1_r[i] <= $signed(base_i[4*B + i*(B+1) +: B+1]) * $signed({1'b0, kk1});
      end
      sat1_r <= flags_i.sat;
      r2_r   <= r_nxt;
      sat2_r <= sat_nxt;
    end
  end

  assign valid_o = vld2_r;
  assign r_o     = r2_r;
  assign sat_o   = sat2_r;
endmodule
`default_nettype wire

// ===== src/quaternion_slerp_unit.sv =====
// quaternion spherical and linear interpolation unit, top level
//
//   channel   direction  transfer when       payload
//   in_ch     sink       valid && ready      first_*, second_*, interp_t
//   out_ch    source     valid && ready      out_x..out_w, saturated
//   cfg_ch    sink       valid (ready = 1)   index, data
//
// one item per cycle while the output is not stalled
// the pipeline holds the root (31 stages), angle, sine (30 each) and divide (31) chains
// a stalled output freezes the whole pipeline and input ready drops with it
// reset clears all stage valid bits and loads the register defaults
`default_nettype none
`include "quaternion_slerp_unit_macros.svh"
module quaternion_slerp_unit import qslerp_pkg::*; #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  qslerp_in_if.sink        in_ch,
  qslerp_out_if.source     out_ch,
  qslerp_cfg_if.sink       cfg_ch
);
  localparam int B   = COMPONENT_BITS;
  localparam int BW  = 8 * B + 4 + T_W;
  localparam int SW1 = BW + 31;

  logic             mode_r;
  logic [THR_W-1:0] thr_r;
  logic             adv;

  logic             d_vld, q_vld, a_vld, s_vld, w_vld, m_vld;
  qs_flags_t        d_flg, q_flg, a_flg, s_flg, w_flg;
  logic [BW-1:0]    d_base, w_base;
  logic [30:0]      d_c, q_s, a_theta, s_sine0, s_sine1, w_k0, w_k1;
  logic [60:0]      d_v;
  logic [SW1-1:0]   q_side, a_side, s_side;
  logic [4*B-1:0]   m_r;
  logic             m_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SPH;
      thr_r  <= THR_W'(16);
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_MODE:   mode_r <= cfg_ch.data[0];
        CFG_THRESH: thr_r  <= cfg_ch.data;
        default:    ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign adv          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = adv;

  qslerp_dot #(.B(B)) u_dot (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .valid_i(in_ch.valid && adv),
    .a_i({in_ch.first_w, in_ch.first_z, in_ch.first_y, in_ch.first_x}),
    .b_i({in_ch.second_w, in_ch.second_z, in_ch.second_y, in_ch.second_x}),
    .t_i(in_ch.interp_t), .mode_i(mode_r), .thr_i(thr_r),
    .valid_o(d_vld), .base_o(d_base), .c_o(d_c), .v_o(d_v), .flags_o(d_flg)
  );

  qslerp_isqrt #(.SIDE_W(SW1)) u_isqrt (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .valid_i(d_vld), .v_i(d_v), .flags_i(d_flg), .side_i({d_base, d_c}),
    .valid_o(q_vld), .s_o(q_s), .flags_o(q_flg), .side_o(q_side)
  );

  qslerp_atan #(.SIDE_W(SW1)) u_atan (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .valid_i(q_vld), .c_i(q_side[30:0]), .s_i(q_s), .flags_i(q_flg),
    .side_i({q_side[SW1-1:31], q_s}),
    .valid_o(a_vld), .theta_o(a_theta), .flags_o(a_flg), .side_o(a_side)
  );

  qslerp_sin2 #(.SIDE_W(SW1)) u_sin2 (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .valid_i(a_vld), .theta_i(a_theta), .t_i(a_side[SW1-1 -: T_W]),
    .flags_i(a_flg), .side_i(a_side),
    .valid_o(s_vld), .sine0_o(s_sine0), .sine1_o(s_sine1),
    .flags_o(s_flg), .side_o(s_side)
  );

  qslerp_div2 #(.SIDE_W(BW)) u_div2 (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .valid_i(s_vld), .sine0_i(s_sine0), .sine1_i(s_sine1), .s_i(s_side[30:0]),
    .flags_i(s_flg), .side_i(s_side[SW1-1:31]),
    .valid_o(w_vld), .k0_o(w_k0), .k1_o(w_k1), .flags_o(w_flg), .side_o(w_base)
  );

  qslerp_mix #(.B(B)) u_mix (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .valid_i(w_vld), .base_i(w_base), .k0_i(w_k0), .k1_i(w_k1), .flags_i(w_flg),
    .valid_o(m_vld), .r_o(m_r), .sat_o(m_sat)
  );

  assign out_ch.valid     = m_vld;
  assign out_ch.out_x     = m_r[0*B +: B];
  assign out_ch.out_y     = m_r[1*B +: B];
  assign out_ch.out_z     = m_r[2*B +: B];
  assign out_ch.out_w     = m_r[3*B +: B];
  assign out_ch.saturated = m_sat;

  `QS_CHECK(a_ready_only_on_stall, in_ch.valid && !in_ch.ready, out_ch.valid && !out_ch.ready)
  `QS_CHECK_NEXT(a_thr_write, cfg_ch.valid && (cfg_idx_t'(cfg_ch.index) == CFG_THRESH), thr_r == $past(cfg_ch.data))
  `QS_CHECK_RST(a_reset_empty, !rst_n, !out_ch.valid)
endmodule
`default_nettype wire
